[sv/cll_pkg.sv]
// ----------------------------------------------------------------------------
// cll_pkg: shared definitions for the cursor linked list engine
// Store geometry, derived widths and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package cll_pkg;

    localparam int SLOTS     = 64;
    localparam int HEAD_SLOT = SLOTS - 1;
    localparam int CAPACITY  = SLOTS - 2;

    localparam int LINK_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = 6;
    localparam int ELEM_W = 8;
    localparam int LEN_W  = 6;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Read address source of the link store.
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_DATA,
        RD_WALK
    } rd_sel_t;

    // Write address source of the link store.
    typedef enum logic [1:0] {
        WA_ZERO,
        WA_NODE,
        WA_CUR,
        WA_INIT
    } wa_sel_t;

    // Write data source of the link store.
    typedef enum logic [1:0] {
        WD_DATA,
        WD_NODE,
        WD_INIT
    } wd_sel_t;

    typedef struct packed {
        logic    load_in;
        logic    init_step;
        logic    link_wr;
        rd_sel_t rd_sel;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        logic    walk;
        logic    node_load;
        logic    elem_wr;
        logic    removed_load;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;
        logic    out_ok;
    } cll_cmd_t;

    typedef struct packed {
        logic mode;
        logic pos_ok;
        logic node_ok;
        logic steps_zero;
        logic init_last;
        logic out_free;
    } cll_sts_t;

endpackage

[sv/cursor_linked_list_engine_core.sv]
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core: cursor linked list engine, top level
// Insert and delete by one-based position in a list kept in a node array.
// ----------------------------------------------------------------------------
// After reset the block sweeps the link store once, one slot per cycle, to
// build the free chain, and s_ready rises once the sweep is done. Each beat
// then runs alone. The longest operation is an insert at position 62. The
// time of an operation is set by the walk along the data chain, one link
// store read per cycle. Out-of-range positions and inserts into a full store
// are refused by the bound check, before any walk. A finished result waits in
// an output register, and the next beat is accepted while it is held.
module cursor_linked_list_engine_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_mode,
    input  logic [cll_pkg::POS_W-1:0]  s_position,
    input  logic [cll_pkg::ELEM_W-1:0] s_element,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_ok,
    output logic [cll_pkg::ELEM_W-1:0] m_removed_element,
    output logic [cll_pkg::LEN_W-1:0]  m_list_length
);
    import cll_pkg::*;

    cll_cmd_t cmd;
    cll_sts_t sts;

    cll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    cll_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_mode            (s_mode),
        .s_position        (s_position),
        .s_element         (s_element),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_removed_element (m_removed_element),
        .m_list_length     (m_list_length),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

[sv/cll_ram.sv]
// ----------------------------------------------------------------------------
// cll_ram: generic simple dual port RAM
// One write port and one read port; read data is registered and returns the
// old contents when the same address is written in the same cycle.
// ----------------------------------------------------------------------------
module cll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/cll_dpath.sv]
// ----------------------------------------------------------------------------
// cll_dpath: datapath of the cursor linked list engine
// Holds the link and element stores, the walk cursor, the element count and
// the result register. The controller's commands steer all but m_valid's clear.
// ----------------------------------------------------------------------------
module cll_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_mode,
    input  logic [cll_pkg::POS_W-1:0]   s_position,
    input  logic [cll_pkg::ELEM_W-1:0]  s_element,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ok,
    output logic [cll_pkg::ELEM_W-1:0]  m_removed_element,
    output logic [cll_pkg::LEN_W-1:0]   m_list_length,
    input  cll_pkg::cll_cmd_t           cmd,
    output cll_pkg::cll_sts_t           sts
);
    import cll_pkg::*;

    logic              mode_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  steps_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic [ELEM_W-1:0] removed_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [LINK_W-1:0] node_reg;
    logic [LINK_W-1:0] cur_reg;
    logic [LINK_W-1:0] init_reg;
    logic              pend_reg;
    logic              m_valid_reg;
    logic              m_ok_reg;
    logic [ELEM_W-1:0] m_removed_reg;
    logic [LEN_W-1:0]  m_len_reg;

    logic              link_we;
    logic [LINK_W-1:0] link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic [LINK_W-1:0] link_raddr;
    logic [LINK_W-1:0] link_rdata;
    logic [ELEM_W-1:0] elem_rdata;
    logic [LINK_W-1:0] walk_addr;
    logic [LINK_W-1:0] init_val;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic              ins_ok;
    logic              del_ok;

    // While a walk read is in flight the cursor is the link just returned.
    assign walk_addr = pend_reg ? link_rdata : cur_reg;

    // Reset image: free chain 0 -> 1 -> ... -> SLOTS-2 -> end, empty data chain.
    assign init_val = (init_reg < LINK_W'(SLOTS - 2)) ? init_reg + LINK_W'(1) : '0;

    always_comb begin
        case (cmd.rd_sel)
            RD_ZERO: link_raddr = '0;
            RD_DATA: link_raddr = link_rdata;
            RD_WALK: link_raddr = walk_addr;
            default: link_raddr = '0;
        endcase
        case (cmd.wa_sel)
            WA_ZERO: link_waddr = '0;
            WA_NODE: link_waddr = node_reg;
            WA_CUR:  link_waddr = cur_reg;
            WA_INIT: link_waddr = init_reg;
            default: link_waddr = '0;
        endcase
        case (cmd.wd_sel)
            WD_DATA: link_wdata = link_rdata;
            WD_NODE: link_wdata = node_reg;
            WD_INIT: link_wdata = init_val;
            default: link_wdata = '0;
        endcase
    end

    assign link_we = cmd.link_wr;

    cll_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk     (aclk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (link_raddr),
        .rd_data (link_rdata)
    );

    cll_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (SLOTS)
    ) u_elem_ram (
        .clk     (aclk),
        .wr_en   (cmd.elem_wr),
        .wr_addr (link_rdata),
        .wr_data (elem_reg),
        .rd_addr (link_rdata),
        .rd_data (elem_rdata)
    );

    assign pos_x  = CMP_W'(pos_reg);
    assign cnt_x  = CMP_W'(count_reg);
    assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1)) &&
                    (cnt_x < CMP_W'(CAPACITY));
    assign del_ok = (pos_x != '0) && (pos_x <= cnt_x);

    assign sts.mode       = mode_reg;
    assign sts.pos_ok     = mode_reg ? del_ok : ins_ok;
    assign sts.node_ok    = (link_rdata != '0) && (link_rdata != LINK_W'(HEAD_SLOT));
    assign sts.steps_zero = (steps_reg == '0);
    assign sts.init_last  = (init_reg == LINK_W'(SLOTS - 1));
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            init_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.init_step) begin
                init_reg <= init_reg + LINK_W'(1);
            end
            if (cmd.load_in) begin
                pend_reg <= 1'b0;
            end else if (cmd.walk) begin
                pend_reg <= 1'b1;
            end
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg    <= s_mode;
            pos_reg     <= s_position;
            elem_reg    <= s_element;
            steps_reg   <= s_position - POS_W'(1);
            cur_reg     <= LINK_W'(HEAD_SLOT);
            removed_reg <= '0;
        end else begin
            if (cmd.walk) begin
                cur_reg <= walk_addr;
                if (steps_reg != '0) begin
                    steps_reg <= steps_reg - POS_W'(1);
                end
            end
            if (cmd.removed_load) begin
                removed_reg <= elem_rdata;
            end
        end
        if (cmd.node_load) begin
            node_reg <= link_rdata;
        end
        if (cmd.out_load) begin
            m_ok_reg      <= cmd.out_ok;
            m_removed_reg <= removed_reg;
            m_len_reg     <= LEN_W'(count_reg);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_ok              = m_ok_reg;
    assign m_removed_element = m_removed_reg;
    assign m_list_length     = m_len_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("element count above capacity");

    a_count_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |=> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))
        else $error("element count did not advance on insert");

    a_refused_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ok_reg |-> m_removed_reg == '0)
        else $error("refused operation reports a removed element");

endmodule

[sv/cll_ctrl.sv]
// ----------------------------------------------------------------------------
// cll_ctrl: controller of the cursor linked list engine
// Sequences the store sweep after reset, the bound check, the free chain pop,
// the walk along the data chain and the splice or unlink of one operation.
// ----------------------------------------------------------------------------
module cll_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output cll_pkg::cll_cmd_t cmd,
    input  cll_pkg::cll_sts_t sts
);
    import cll_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_INS_FREE,
        ST_INS_NODE,
        ST_INS_POP,
        ST_WALK,
        ST_INS_LINK,
        ST_INS_SPLICE,
        ST_DEL_VICT,
        ST_DEL_UNLINK,
        ST_DEL_FREE,
        ST_DEL_PUSH,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ok_reg, ok_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ok_next    = ok_reg;
        case (state_reg)
            ST_INIT: begin
                cmd.link_wr   = 1'b1;
                cmd.wa_sel    = WA_INIT;
                cmd.wd_sel    = WD_INIT;
                cmd.init_step = 1'b1;
                if (sts.init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!sts.pos_ok) begin
                    ok_next    = 1'b0;
                    state_next = ST_FINISH;
                end else if (sts.mode) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_INS_FREE;
                end
            end
            ST_INS_FREE: begin
                cmd.rd_sel = RD_ZERO;
                state_next = ST_INS_NODE;
            end
            ST_INS_NODE: begin
                // The free chain head is on the read port; fetch its link.
                if (sts.node_ok) begin
                    cmd.node_load = 1'b1;
                    cmd.elem_wr   = 1'b1;
                    cmd.rd_sel    = RD_DATA;
                    state_next    = ST_INS_POP;
                end else begin
                    ok_next    = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_INS_POP: begin
                cmd.link_wr = 1'b1;
                cmd.wa_sel  = WA_ZERO;
                cmd.wd_sel  = WD_DATA;
                state_next  = ST_WALK;
            end
            ST_WALK: begin
                // One link per cycle; the last read fetches the link of the
                // node ahead of the target position.
                cmd.rd_sel = RD_WALK;
                cmd.walk   = 1'b1;
                if (sts.steps_zero) begin
                    state_next = sts.mode ? ST_DEL_VICT : ST_INS_LINK;
                end
            end
            ST_INS_LINK: begin
                cmd.link_wr = 1'b1;
                cmd.wa_sel  = WA_NODE;
                cmd.wd_sel  = WD_DATA;
                state_next  = ST_INS_SPLICE;
            end
            ST_INS_SPLICE: begin
                cmd.link_wr = 1'b1;
                cmd.wa_sel  = WA_CUR;
                cmd.wd_sel  = WD_NODE;
                cmd.cnt_inc = 1'b1;
                ok_next     = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_DEL_VICT: begin
                if (sts.node_ok) begin
                    cmd.node_load = 1'b1;
                    cmd.rd_sel    = RD_DATA;
                    state_next    = ST_DEL_UNLINK;
                end else begin
                    ok_next    = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_DEL_UNLINK: begin
                cmd.link_wr      = 1'b1;
                cmd.wa_sel       = WA_CUR;
                cmd.wd_sel       = WD_DATA;
                cmd.removed_load = 1'b1;
                cmd.rd_sel       = RD_ZERO;
                state_next       = ST_DEL_FREE;
            end
            ST_DEL_FREE: begin
                cmd.link_wr = 1'b1;
                cmd.wa_sel  = WA_NODE;
                cmd.wd_sel  = WD_DATA;
                state_next  = ST_DEL_PUSH;
            end
            ST_DEL_PUSH: begin
                cmd.link_wr = 1'b1;
                cmd.wa_sel  = WA_ZERO;
                cmd.wd_sel  = WD_NODE;
                cmd.cnt_dec = 1'b1;
                ok_next     = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_ok   = ok_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            ok_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

endmodule

[tb/tb_cursor_linked_list_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cursor_linked_list_engine_core: self-checking bench for the list engine
// A driver streams insert and delete beats in random bursts. A shadow copy of
// the node array predicts status, removed byte and length for every beat.
// A monitor compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cursor_linked_list_engine_core;
    import cll_pkg::*;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;
    localparam int   STALL_LIMIT = 5000;
    localparam int   RANDOM_OPS  = 1700;

    typedef struct {
        logic              mode;
        logic [POS_W-1:0]  pos;
        logic [ELEM_W-1:0] elem;
        bit                hold;
    } list_op_t;

    typedef struct packed {
        logic              ok;
        logic [ELEM_W-1:0] removed;
        logic [LEN_W-1:0]  length;
    } list_outcome_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_mode = 1'b0;
    logic [POS_W-1:0]    s_position = '0;
    logic [ELEM_W-1:0]   s_element = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_ok;
    logic [ELEM_W-1:0]   m_removed_element;
    logic [LEN_W-1:0]    m_list_length;

    cursor_linked_list_engine_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_position        (s_position),
        .s_element         (s_element),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_removed_element (m_removed_element),
        .m_list_length     (m_list_length)
    );

    // Shadow of the node array and the element count.
    logic [LINK_W-1:0] next_link [SLOTS];
    logic [ELEM_W-1:0] node_byte [SLOTS];
    int unsigned       live_count;

    list_op_t      op_q[$];
    list_outcome_t list_outcomes_q[$];
    int unsigned   gen_count;
    int unsigned   random_made;
    int unsigned   errors;
    int unsigned   ops_sent;
    int unsigned   results_seen;
    int unsigned   cycle_no;
    int unsigned   idle_cycles;
    int unsigned   burst_left;
    int unsigned   gap_left;
    int unsigned   hold_left;
    int unsigned   next_hold_at;
    list_op_t      nxt;
    list_outcome_t want;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic clear_list_shadow();
        for (int i = 0; i < SLOTS; i++) begin
            next_link[i] = '0;
            node_byte[i] = '0;
        end
        for (int i = 0; i + 1 < HEAD_SLOT; i++)
            next_link[i] = LINK_W'(i + 1);
        live_count = 0;
    endtask

    // Applies one beat to the shadow list and records the result it must give.
    task automatic apply_list_op(input logic mode, input logic [POS_W-1:0] pos,
                                 input logic [ELEM_W-1:0] elem);
        list_outcome_t     res;
        logic [LINK_W-1:0] node;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] victim;
        res.ok      = 1'b0;
        res.removed = '0;
        prev        = LINK_W'(HEAD_SLOT);
        if (mode == OP_INSERT) begin
            node = next_link[0];
            if (pos >= 1 && pos <= live_count + 1 && live_count < CAPACITY &&
                node != 0 && node != HEAD_SLOT) begin
                next_link[0] = next_link[node];
                node_byte[node] = elem;
                for (int k = 1; k < pos; k++)
                    prev = next_link[prev];
                next_link[node] = next_link[prev];
                next_link[prev] = node;
                live_count++;
                res.ok = 1'b1;
            end
        end else if (pos >= 1 && pos <= live_count) begin
            for (int k = 1; k < pos; k++)
                prev = next_link[prev];
            victim = next_link[prev];
            if (victim != 0 && victim != HEAD_SLOT) begin
                res.removed = node_byte[victim];
                next_link[prev] = next_link[victim];
                next_link[victim] = next_link[0];
                next_link[0] = victim;
                live_count--;
                res.ok = 1'b1;
            end
        end
        res.length = LEN_W'(live_count);
        list_outcomes_q.push_back(res);
    endtask

    // Queues a beat and tracks the list length the beat will leave behind.
    task automatic queue_op(input logic mode, input int pos, input int elem, input bit hold);
        list_op_t op;
        op.mode = mode;
        op.pos  = POS_W'(pos);
        op.elem = ELEM_W'(elem);
        op.hold = hold;
        op_q.push_back(op);
        if (mode == OP_INSERT) begin
            if (pos >= 1 && pos <= gen_count + 1 && gen_count < CAPACITY)
                gen_count++;
        end else if (pos >= 1 && pos <= gen_count) begin
            gen_count--;
        end
    endtask

    task automatic queue_random(input logic mode, input int pos);
        queue_op(mode, pos, $urandom_range(0, 255), $urandom_range(0, 149) == 0);
        random_made++;
    endtask

    task automatic queue_noise();
        queue_random(logic'($urandom_range(0, 1)), $urandom_range(0, 63));
    endtask

    // Stimulus
    initial begin
        int          seg;
        int          pick;
        int unsigned total_ops;
        clear_list_shadow();
        gen_count   = 0;
        random_made = 0;
        errors      = 0;

        queue_op(OP_DELETE, 1, 8'h00, 0);    // delete from an empty list
        queue_op(OP_INSERT, 0, 8'h11, 0);    // position zero
        queue_op(OP_INSERT, 2, 8'h22, 0);    // insert beyond end
        queue_op(OP_INSERT, 1, 8'h00, 0);
        queue_op(OP_INSERT, 1, 8'hFF, 0);
        queue_op(OP_INSERT, 3, 8'hA5, 0);    // append at the tail
        queue_op(OP_INSERT, 2, 8'h5A, 0);
        queue_op(OP_DELETE, 0, 8'hFF, 0);    // position zero
        queue_op(OP_DELETE, 5, 8'h00, 0);    // delete beyond end
        queue_op(OP_INSERT, 63, 8'h80, 0);
        queue_op(OP_DELETE, 63, 8'h7F, 0);
        queue_op(OP_DELETE, 2, 8'h00, 1);
        queue_op(OP_DELETE, 3, 8'h00, 0);
        queue_op(OP_DELETE, 3, 8'h00, 0);
        queue_op(OP_INSERT, 4, 8'h01, 0);
        queue_op(OP_DELETE, 1, 8'h00, 0);
        queue_op(OP_DELETE, 1, 8'h00, 0);
        queue_op(OP_DELETE, 1, 8'h00, 0);
        queue_op(OP_INSERT, 1, 8'h7E, 0);
        queue_op(OP_DELETE, 1, 8'h00, 0);

        while (random_made < RANDOM_OPS) begin
            seg = $urandom_range(0, 5);
            case (seg)
                0, 1: begin
                    // Grow the list to full, then knock on the full store.
                    while (gen_count < CAPACITY) begin
                        if ($urandom_range(0, 7) == 0)
                            queue_noise();
                        else
                            queue_random(OP_INSERT, $urandom_range(1, gen_count + 1));
                    end
                    repeat ($urandom_range(1, 3))
                        queue_random(OP_INSERT, $urandom_range(1, 63));
                end
                2, 3: begin
                    while (gen_count > 0) begin
                        if ($urandom_range(0, 7) == 0)
                            queue_noise();
                        else
                            queue_random(OP_DELETE, $urandom_range(1, gen_count));
                    end
                    queue_random(OP_DELETE, $urandom_range(1, 63));
                end
                4: begin
                    repeat (40) begin
                        if ($urandom_range(0, 1) == 0)
                            queue_noise();
                        else
                            queue_random(logic'($urandom_range(0, 1)),
                                         $urandom_range(0, gen_count + 2));
                    end
                end
                default: begin
                    // Mixed traffic that favors the head and tail of the list.
                    repeat (60) begin
                        pick = $urandom_range(0, 3);
                        if ($urandom_range(0, 1) == 0 && gen_count < CAPACITY)
                            queue_random(OP_INSERT, (pick == 0) ? 1 :
                                         (pick == 1) ? gen_count + 1 :
                                         $urandom_range(1, gen_count + 1));
                        else
                            queue_random(OP_DELETE, (pick == 0) ? 1 :
                                         (pick == 1 || gen_count == 0) ? gen_count :
                                         $urandom_range(1, gen_count));
                    end
                end
            endcase
        end
        total_ops = op_q.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // The driver counts a beat and records its prediction in one step.
        while (ops_sent != total_ops || list_outcomes_q.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge aclk) begin
        cycle_no <= (aresetn) ? cycle_no + 1 : 0;
    end

    // Driver: bursts of beats with random gaps, plus long stretches with none.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_mode     <= 1'b0;
            s_position <= '0;
            s_element  <= '0;
            ops_sent   = 0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_list_op(s_mode, s_position, s_element);
                ops_sent++;
            end
            if (s_valid && !s_ready) begin
                // Beat still waiting; payload stays put.
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (op_q.size() != 0 &&
                         !(op_q[0].hold && (s_valid || list_outcomes_q.size() != 0))) begin
                nxt = op_q.pop_front();
                s_valid    <= 1'b1;
                s_mode     <= nxt.mode;
                s_position <= nxt.pos;
                s_element  <= nxt.elem;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ((ops_sent / 256) % 4 == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: rotating stall patterns and a few long hold-offs.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            hold_left    = 0;
            next_hold_at = 300;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (results_seen >= next_hold_at) begin
            hold_left = 400;
            next_hold_at += 700;
            m_ready <= 1'b0;
        end else begin
            case ((cycle_no / 1500) % 3)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // Monitor: each result beat against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            results_seen <= 0;
        end else if (m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (list_outcomes_q.size() == 0) begin
                $display("%0t: unexpected result beat ok=%0d removed=%0h length=%0d",
                         $time, m_ok, m_removed_element, m_list_length);
                errors++;
            end else begin
                want = list_outcomes_q.pop_front();
                if (m_ok !== want.ok) begin
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, m_ok);
                    errors++;
                end
                if (m_removed_element !== want.removed) begin
                    $display("%0t: removed_element expected %0h actual %0h",
                             $time, want.removed, m_removed_element);
                    errors++;
                end
                if (m_list_length !== want.length) begin
                    $display("%0t: list_length expected %0d actual %0d",
                             $time, want.length, m_list_length);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

[sim.f]
sv/cll_pkg.sv
sv/cll_ram.sv
sv/cll_dpath.sv
sv/cll_ctrl.sv
sv/cursor_linked_list_engine_core.sv
tb/tb_cursor_linked_list_engine_core.sv
